@@ hw/rtl/culi_pkg.sv @@
// Shared types, codes and fixed coefficients for the compact upwind line interpolator.
// Used by every module of the block; depends on nothing else.
package culi_pkg;

  // Ghost cells on each side of a line.
  localparam int GHOST_CELLS = 3;
  // Width of an interface index; covers the whole range of the line length.
  localparam int IDX_W = 6;
  // Quotient bits produced by the reciprocal divider.
  localparam int DIV_STEPS = 61;

  // Configuration register indexes.
  localparam logic CFG_UPWIND_LEFT  = 1'b0;
  localparam logic CFG_ACTIVE_CELLS = 1'b1;

  // Q2.30 coefficients, rounded to nearest.
  localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
  localparam logic signed [31:0] C_3_10  = 32'sd322122547;
  localparam logic signed [31:0] C_6_10  = 32'sd644245094;
  localparam logic signed [31:0] C_1_10  = 32'sd107374182;
  localparam logic signed [31:0] C_1_30  = 32'sd35791394;
  localparam logic signed [31:0] C_13_60 = -32'sd232644062;
  localparam logic signed [31:0] C_47_60 = 32'sd841097762;
  localparam logic signed [31:0] C_27_60 = 32'sd483183821;
  localparam logic signed [31:0] C_1_20  = -32'sd53687091;
  localparam logic signed [31:0] C_19_30 = 32'sd680036489;
  localparam logic signed [31:0] C_1_3   = 32'sd357913941;

  localparam logic signed [47:0] SAT48_MAX = 48'sh7fff_ffff_ffff;
  localparam logic signed [47:0] SAT48_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic signed [31:0] cell_value;
    logic               line_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] interface_value;
    logic               last_interface;
  } out_beat_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR,
    OP_TAP_RD,
    OP_TAP_MUL,
    OP_TAP_ACC,
    OP_ROUND,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_MUL_SUM,
    OP_DEN,
    OP_DIVGO,
    OP_RECIP,
    OP_NUM,
    OP_CPREV,
    OP_DPREV,
    OP_BK_RD,
    OP_BK_SET,
    OP_BK_X,
    OP_OUT_RD,
    OP_OUT_LOAD
  } dp_op_t;

  // Operand pairs of the shared Q30 multiply.
  typedef enum logic [2:0] {
    MSEL_CPREV_A,
    MSEL_DPREV_A,
    MSEL_C_RECIP,
    MSEL_NUM_RECIP,
    MSEL_X_UPPER
  } msel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_TAP_RD,
    ST_TAP_MUL,
    ST_TAP_ACC,
    ST_ROUND,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_MUL_SUM,
    ST_DEN,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_RECIP,
    ST_NUM,
    ST_CPREV,
    ST_DPREV,
    ST_BK_RD,
    ST_BK_SET,
    ST_BK_X,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } state_t;

  typedef struct packed {
    dp_op_t             op;
    msel_t              msel;
    logic [IDX_W-1:0]   idx;
    logic [2:0]         tap;
    logic               edge_row;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic div_done;
  } dp_sts_t;

  // Stencil weight of one tap; edge rows use five taps, inner rows taps one to three.
  function automatic logic signed [31:0] tap_coef(input logic edge_row, input logic [2:0] tap);
    logic signed [31:0] r;
    r = '0;
    if (edge_row) begin
      unique case (tap)
        3'd0:    r = C_1_30;
        3'd1:    r = C_13_60;
        3'd2:    r = C_47_60;
        3'd3:    r = C_27_60;
        3'd4:    r = C_1_20;
        default: r = '0;
      endcase
    end else begin
      unique case (tap)
        3'd1:    r = C_1_30;
        3'd2:    r = C_19_30;
        3'd3:    r = C_1_3;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  // Saturate a wide intermediate to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [47:0] r;
    if (v > 52'(SAT48_MAX)) r = SAT48_MAX;
    else if (v < 52'(SAT48_MIN)) r = SAT48_MIN;
    else r = v[47:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/culi_div.sv @@
// Restoring divider that forms round(2^60 / den) one quotient bit per cycle.
// Depends on culi_pkg for the step count.
module culi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic [60:0] dvd;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic [32:0] trial;
  logic        qbit;

  // Shift the next dividend bit into the partial remainder and compare.
  always_comb begin
    trial = {rem[31:0], dvd[60]};
    qbit  = (trial >= {1'b0, divisor});
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(culi_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient; the dividend carries half the divisor for rounding.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= (61'd1 << 60) | 61'(divisor >> 1);
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      rem      <= qbit ? (trial - {1'b0, divisor}) : trial;
      quotient <= {quotient[30:0], qbit};
      dvd      <= dvd << 1;
    end
  end

endmodule

@@ hw/rtl/culi_datapath.sv @@
// Datapath: line store, tap accumulator, shared multiply, Thomas memories, output register.
// Depends on culi_pkg and culi_div.
module culi_datapath #(
  parameter int MAX_CELLS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                upwind_left,
  input  culi_pkg::in_beat_t  in_beat,
  input  culi_pkg::dp_cmd_t   cmd,
  input  logic                last,
  output culi_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output culi_pkg::out_beat_t out_data
);

  localparam int STORE_DEPTH = MAX_CELLS + 2 * culi_pkg::GHOST_CELLS;
  localparam int SAW         = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int IFACE_DEPTH = MAX_CELLS + 1;
  localparam int IAW         = $clog2(IFACE_DEPTH);

  logic signed [31:0] store_mem [STORE_DEPTH];
  logic signed [47:0] upper_mem [IFACE_DEPTH];
  logic signed [47:0] rhs_mem   [IFACE_DEPTH];

  logic [CNT_W-1:0]   cell_count;
  logic signed [31:0] cell_q;
  logic signed [47:0] upper_q, rhs_q;
  logic signed [63:0] acc;
  logic signed [47:0] rhs_r, cprev, dprev, num, xv;
  logic signed [31:0] den, recip;
  logic signed [64:0] mprod, mhi;
  logic signed [51:0] mres;

  logic [SAW:0]       tap_sum;
  logic [SAW-1:0]     tap_addr;
  logic [IAW-1:0]     ia;
  logic signed [31:0] a_coef, b_coef, c_coef;
  logic signed [47:0] mx;
  logic signed [31:0] mk;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [80:0] msum;
  logic signed [63:0] acc_rnd;
  logic signed [51:0] den_full;
  logic signed [47:0] xv_new;
  logic signed [48:0] y_rnd;
  logic signed [40:0] y_sh;
  logic signed [31:0] y_sat;
  logic               div_start, div_busy, div_done;
  logic [31:0]        div_q;
  logic               rhs_we;
  logic signed [47:0] rhs_wd;

  // Store address of a stencil tap; the right-biased stencil runs mirrored.
  always_comb begin
    if (upwind_left) begin
      tap_sum = (SAW + 1)'(cmd.idx) + (SAW + 1)'(cmd.tap);
    end else begin
      tap_sum = (SAW + 1)'(cmd.idx) + (SAW + 1)'(5) - (SAW + 1)'(cmd.tap);
    end
    tap_addr = tap_sum[SAW-1:0];
    ia       = cmd.idx[IAW-1:0];
  end

  // Row coefficients of the tridiagonal system.
  always_comb begin
    if (cmd.edge_row) begin
      a_coef = '0;
      b_coef = culi_pkg::Q30_ONE;
      c_coef = '0;
    end else begin
      a_coef = upwind_left ? culi_pkg::C_3_10 : culi_pkg::C_1_10;
      b_coef = culi_pkg::C_6_10;
      c_coef = upwind_left ? culi_pkg::C_1_10 : culi_pkg::C_3_10;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd.msel)
      culi_pkg::MSEL_CPREV_A:   begin mx = cprev;       mk = a_coef; end
      culi_pkg::MSEL_DPREV_A:   begin mx = dprev;       mk = a_coef; end
      culi_pkg::MSEL_C_RECIP:   begin mx = 48'(c_coef); mk = recip;  end
      culi_pkg::MSEL_NUM_RECIP: begin mx = num;         mk = recip;  end
      culi_pkg::MSEL_X_UPPER:   begin mx = xv;          mk = upper_q[31:0]; end
      default:                  begin mx = xv;          mk = a_coef; end
    endcase
    if (cmd.op == culi_pkg::OP_TAP_MUL) begin
      mul_a = 33'(cell_q);
      mul_b = culi_pkg::tap_coef(cmd.edge_row, cmd.tap);
    end else if (cmd.op == culi_pkg::OP_MUL_LO) begin
      mul_a = $signed({17'd0, mx[15:0]});
      mul_b = mk;
    end else begin
      mul_a = 33'($signed(mx[47:16]));
      mul_b = mk;
    end
    mul_p = mul_a * mul_b;
  end

  // Arithmetic that feeds the registers below.
  always_comb begin
    msum     = (81'(mhi) <<< 16) + 81'(mprod) + 81'(64'sd536870912);
    acc_rnd  = (acc + 64'sd2097152) >>> 22;
    den_full = 52'(b_coef) - mres;
    xv_new   = culi_pkg::sat48(52'(rhs_q) - mres);
    y_rnd    = 49'(rhs_q) + 49'sd128;
    y_sh     = 41'(y_rnd >>> 8);
    if (y_sh > 41'sd2147483647) y_sat = 32'sh7fff_ffff;
    else if (y_sh < -41'sd2147483648) y_sat = 32'sh8000_0000;
    else y_sat = y_sh[31:0];
    div_start = (cmd.op == culi_pkg::OP_DIVGO);
  end

  // Write port of the right-side memory: forward sweep and back substitution.
  always_comb begin
    rhs_we = 1'b0;
    rhs_wd = xv_new;
    unique case (cmd.op)
      culi_pkg::OP_DPREV:  begin rhs_we = 1'b1; rhs_wd = culi_pkg::sat48(mres); end
      culi_pkg::OP_BK_SET: begin rhs_we = 1'b1; rhs_wd = rhs_q; end
      culi_pkg::OP_BK_X:   begin rhs_we = 1'b1; rhs_wd = xv_new; end
      default:             rhs_we = 1'b0;
    endcase
  end

  // Line store: write on each loaded beat while there is room, read one tap per tap-read command.
  always_ff @(posedge clk) begin
    if (cmd.op == culi_pkg::OP_LOAD && cell_count < CNT_W'(STORE_DEPTH)) begin
      store_mem[cell_count[SAW-1:0]] <= in_beat.cell_value;
    end
    if (cmd.op == culi_pkg::OP_TAP_RD) begin
      cell_q <= store_mem[tap_addr];
    end
  end

  // Cell counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count <= '0;
    end else if (cmd.op == culi_pkg::OP_LOAD) begin
      if (in_beat.line_end) cell_count <= '0;
      else if (cell_count < CNT_W'(STORE_DEPTH)) cell_count <= cell_count + CNT_W'(1);
    end
  end

  // Thomas memories.
  always_ff @(posedge clk) begin
    if (cmd.op == culi_pkg::OP_DPREV) begin
      upper_mem[ia] <= cprev;
    end
    if (rhs_we) begin
      rhs_mem[ia] <= rhs_wd;
    end
    if (cmd.op == culi_pkg::OP_BK_RD) begin
      upper_q <= upper_mem[ia];
      rhs_q   <= rhs_mem[ia];
    end else if (cmd.op == culi_pkg::OP_OUT_RD) begin
      rhs_q <= rhs_mem[ia];
    end
  end

  // Working registers of the forward and back sweeps.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      culi_pkg::OP_CLR: begin
        acc <= '0;
        if (cmd.idx == '0) begin
          cprev <= '0;
          dprev <= '0;
        end
      end
      culi_pkg::OP_TAP_MUL: mprod <= mul_p;
      culi_pkg::OP_TAP_ACC: acc <= acc + mprod[63:0];
      culi_pkg::OP_ROUND:   rhs_r <= acc_rnd[47:0];
      culi_pkg::OP_MUL_HI:  mprod <= mul_p;
      culi_pkg::OP_MUL_LO: begin
        mhi   <= mprod;
        mprod <= mul_p;
      end
      culi_pkg::OP_MUL_SUM: mres <= 52'($signed(msum[80:30]));
      culi_pkg::OP_DEN: begin
        if (den_full < 52'sd536870912) den <= 32'sd536870912;
        else den <= den_full[31:0];
      end
      culi_pkg::OP_RECIP: begin
        if (div_q > 32'h7fff_ffff) recip <= 32'sh7fff_ffff;
        else recip <= $signed(div_q);
      end
      culi_pkg::OP_NUM:    num <= culi_pkg::sat48(52'(rhs_r) - mres);
      culi_pkg::OP_CPREV:  cprev <= culi_pkg::sat48(mres);
      culi_pkg::OP_DPREV:  dprev <= culi_pkg::sat48(mres);
      culi_pkg::OP_BK_SET: xv <= rhs_q;
      culi_pkg::OP_BK_X:   xv <= xv_new;
      default: ;
    endcase
  end

  // Output register: a beat waits here until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == culi_pkg::OP_OUT_LOAD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == culi_pkg::OP_OUT_LOAD) begin
      out_data.interface_value <= y_sat;
      out_data.last_interface  <= last;
    end
  end

  culi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    sts.out_valid = out_valid;
    sts.div_done  = div_done & ~div_busy;
  end

endmodule

@@ hw/rtl/culi_ctrl.sv @@
// Controller: sequences loading, the forward sweep, back substitution and output.
// Depends on culi_pkg.
module culi_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         line_end,
  output logic                         in_ready,
  input  logic                         out_ready,
  input  logic [culi_pkg::IDX_W-1:0]   n,
  input  culi_pkg::dp_sts_t            sts,
  output culi_pkg::dp_cmd_t            cmd,
  output logic                         last
);

  culi_pkg::state_t          state, state_next;
  culi_pkg::msel_t           msel, msel_next;
  logic [culi_pkg::IDX_W-1:0] idx, idx_next;
  logic [2:0]                tap, tap_next;
  logic                      edge_row;

  assign edge_row = (idx == '0) || (idx == n);
  assign last     = (idx == n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= culi_pkg::ST_IDLE;
      msel  <= culi_pkg::MSEL_CPREV_A;
      idx   <= '0;
      tap   <= '0;
    end else begin
      state <= state_next;
      msel  <= msel_next;
      idx   <= idx_next;
      tap   <= tap_next;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_next   = state;
    msel_next    = msel;
    idx_next     = idx;
    tap_next     = tap;
    in_ready     = 1'b0;
    cmd.op       = culi_pkg::OP_NONE;
    cmd.msel     = msel;
    cmd.idx      = idx;
    cmd.tap      = tap;
    cmd.edge_row = edge_row;
    unique case (state)
      culi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = culi_pkg::OP_LOAD;
          if (line_end) begin
            idx_next   = '0;
            state_next = culi_pkg::ST_CLR;
          end
        end
      end
      culi_pkg::ST_CLR: begin
        cmd.op     = culi_pkg::OP_CLR;
        tap_next   = edge_row ? 3'd0 : 3'd1;
        state_next = culi_pkg::ST_TAP_RD;
      end
      culi_pkg::ST_TAP_RD: begin
        cmd.op     = culi_pkg::OP_TAP_RD;
        state_next = culi_pkg::ST_TAP_MUL;
      end
      culi_pkg::ST_TAP_MUL: begin
        cmd.op     = culi_pkg::OP_TAP_MUL;
        state_next = culi_pkg::ST_TAP_ACC;
      end
      culi_pkg::ST_TAP_ACC: begin
        cmd.op = culi_pkg::OP_TAP_ACC;
        if (tap == (edge_row ? 3'd4 : 3'd3)) begin
          state_next = culi_pkg::ST_ROUND;
        end else begin
          tap_next   = tap + 3'd1;
          state_next = culi_pkg::ST_TAP_RD;
        end
      end
      culi_pkg::ST_ROUND: begin
        cmd.op     = culi_pkg::OP_ROUND;
        msel_next  = culi_pkg::MSEL_CPREV_A;
        state_next = culi_pkg::ST_MUL_HI;
      end
      culi_pkg::ST_MUL_HI: begin
        cmd.op     = culi_pkg::OP_MUL_HI;
        state_next = culi_pkg::ST_MUL_LO;
      end
      culi_pkg::ST_MUL_LO: begin
        cmd.op     = culi_pkg::OP_MUL_LO;
        state_next = culi_pkg::ST_MUL_SUM;
      end
      culi_pkg::ST_MUL_SUM: begin
        cmd.op = culi_pkg::OP_MUL_SUM;
        unique case (msel)
          culi_pkg::MSEL_CPREV_A:   state_next = culi_pkg::ST_DEN;
          culi_pkg::MSEL_DPREV_A:   state_next = culi_pkg::ST_NUM;
          culi_pkg::MSEL_C_RECIP:   state_next = culi_pkg::ST_CPREV;
          culi_pkg::MSEL_NUM_RECIP: state_next = culi_pkg::ST_DPREV;
          culi_pkg::MSEL_X_UPPER:   state_next = culi_pkg::ST_BK_X;
          default:                  state_next = culi_pkg::ST_IDLE;
        endcase
      end
      culi_pkg::ST_DEN: begin
        cmd.op     = culi_pkg::OP_DEN;
        state_next = culi_pkg::ST_DIVGO;
      end
      culi_pkg::ST_DIVGO: begin
        cmd.op     = culi_pkg::OP_DIVGO;
        state_next = culi_pkg::ST_DIVWAIT;
      end
      culi_pkg::ST_DIVWAIT: begin
        if (sts.div_done) state_next = culi_pkg::ST_RECIP;
      end
      culi_pkg::ST_RECIP: begin
        cmd.op     = culi_pkg::OP_RECIP;
        msel_next  = culi_pkg::MSEL_DPREV_A;
        state_next = culi_pkg::ST_MUL_HI;
      end
      culi_pkg::ST_NUM: begin
        cmd.op     = culi_pkg::OP_NUM;
        msel_next  = culi_pkg::MSEL_C_RECIP;
        state_next = culi_pkg::ST_MUL_HI;
      end
      culi_pkg::ST_CPREV: begin
        cmd.op     = culi_pkg::OP_CPREV;
        msel_next  = culi_pkg::MSEL_NUM_RECIP;
        state_next = culi_pkg::ST_MUL_HI;
      end
      culi_pkg::ST_DPREV: begin
        cmd.op = culi_pkg::OP_DPREV;
        if (idx == n) begin
          state_next = culi_pkg::ST_BK_RD;
        end else begin
          idx_next   = idx + culi_pkg::IDX_W'(1);
          state_next = culi_pkg::ST_CLR;
        end
      end
      culi_pkg::ST_BK_RD: begin
        cmd.op = culi_pkg::OP_BK_RD;
        if (idx == n) begin
          state_next = culi_pkg::ST_BK_SET;
        end else begin
          msel_next  = culi_pkg::MSEL_X_UPPER;
          state_next = culi_pkg::ST_MUL_HI;
        end
      end
      culi_pkg::ST_BK_SET, culi_pkg::ST_BK_X: begin
        cmd.op = (state == culi_pkg::ST_BK_SET) ? culi_pkg::OP_BK_SET : culi_pkg::OP_BK_X;
        if (idx == '0) begin
          state_next = culi_pkg::ST_OUT_RD;
        end else begin
          idx_next   = idx - culi_pkg::IDX_W'(1);
          state_next = culi_pkg::ST_BK_RD;
        end
      end
      culi_pkg::ST_OUT_RD: begin
        cmd.op     = culi_pkg::OP_OUT_RD;
        state_next = culi_pkg::ST_OUT_LOAD;
      end
      culi_pkg::ST_OUT_LOAD: begin
        cmd.op     = culi_pkg::OP_OUT_LOAD;
        state_next = culi_pkg::ST_OUT_WAIT;
      end
      culi_pkg::ST_OUT_WAIT: begin
        if (out_ready) begin
          if (idx == n) begin
            state_next = culi_pkg::ST_IDLE;
          end else begin
            idx_next   = idx + culi_pkg::IDX_W'(1);
            state_next = culi_pkg::ST_OUT_RD;
          end
        end
      end
      default: state_next = culi_pkg::ST_IDLE;
    endcase
  end

  // A beat is on offer exactly while the controller waits for it to be taken.
  a_wait_has_beat: assert property (@(posedge clk) disable iff (rst)
    (state == culi_pkg::ST_OUT_WAIT) |-> sts.out_valid)
    else $error("output wait without a pending beat");

  // No beat is left pending once the line is finished.
  a_idle_no_beat: assert property (@(posedge clk) disable iff (rst)
    (state == culi_pkg::ST_IDLE) |-> !sts.out_valid)
    else $error("beat pending while idle");

  // Divider completion moves the sweep on.
  a_div_advance: assert property (@(posedge clk) disable iff (rst)
    (state == culi_pkg::ST_DIVWAIT && sts.div_done) |=> (state == culi_pkg::ST_RECIP))
    else $error("divider result not taken");

endmodule

@@ hw/rtl/compact_upwind_line_interpolator.sv @@
// Top level of the compact upwind line interpolator: configuration registers and wiring.
// Depends on culi_pkg, culi_ctrl and culi_datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data   (cell_value, line_end)
//   out      output     out_valid / out_ready  out_data  (interface_value, last_interface)
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// Each cell beat is taken while the block is idle. The beat with line_end starts the solve.
// The forward sweep handles each interface in turn: the stencil taps are read, multiplied and
// summed, then the Thomas step runs its shared multiplies around a wait on the 61-step
// reciprocal divider. Back substitution then walks the interfaces down, with one multiply per
// interface but the last, and the output beats follow in order, one interface at a time.
// Reset is synchronous; no clearing pass is needed. Input is held off during the solve,
// and the output side may stall at any beat.
module compact_upwind_line_interpolator #(
  parameter int MAX_CELLS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  culi_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output culi_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [5:0]          cfg_data
);

  logic                        upwind_left;
  logic [5:0]                  active_cells;
  logic [culi_pkg::IDX_W-1:0]  n;
  culi_pkg::dp_cmd_t           cmd;
  culi_pkg::dp_sts_t           sts;
  logic                        last;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      upwind_left  <= 1'b1;
      active_cells <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        culi_pkg::CFG_UPWIND_LEFT:  upwind_left  <= cfg_data[0];
        culi_pkg::CFG_ACTIVE_CELLS: active_cells <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line length held to its legal range.
  always_comb begin
    if (active_cells < 6'd4) n = culi_pkg::IDX_W'(4);
    else if (active_cells > 6'(MAX_CELLS)) n = culi_pkg::IDX_W'(MAX_CELLS);
    else n = culi_pkg::IDX_W'(active_cells);
  end

  culi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .line_end  (in_data.line_end),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .n         (n),
    .sts       (sts),
    .cmd       (cmd),
    .last      (last)
  );

  culi_datapath #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .upwind_left (upwind_left),
    .in_beat     (in_data),
    .cmd         (cmd),
    .last        (last),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
